[sv/ptti_pkg.sv]
// shared constants and types for the pose table time interpolator
// no dependencies
package ptti_pkg;
    localparam int TableDepth = 64;
    localparam int IdxW = $clog2(TableDepth);
    localparam int CntW = IdxW + 1;
    localparam int TimeW = 48;
    localparam int ValW = 32;
    localparam int NumFields = 6;
    localparam int RatioW = 17;
    localparam int QuotW = 18;

    typedef logic [1:0] t_action;
    localparam t_action ActClear = 2'd0;
    localparam t_action ActAppend = 2'd1;
    localparam t_action ActQuery = 2'd2;

    typedef logic [1:0] t_status;
    localparam t_status StInterp = 2'd0;
    localparam t_status StLast = 2'd1;
    localparam t_status StFirst = 2'd2;
    localparam t_status StEmpty = 2'd3;

    typedef logic [ValW-1:0] t_val;
    typedef t_val t_vals [NumFields];

    // one step of the restoring divider cell chain
    typedef struct packed {
        logic [TimeW:0] rem;
        logic [QuotW-1:0] quot;
    } t_div;
endpackage

[sv/pose_table_time_interpolator_core.sv]
// pose table time interpolator top level: table memory, scan sequencer,
// divider cell chain and mixing stage; depends on ptti_pkg and ptti_div_cell
//
// usage: one input channel carries clear, append and query beats, one output
// channel carries a result beat for each query only.
// clear and append complete as they are accepted. a query reads the timestamp
// memory entry by entry (up to the whole table), fetches the earlier entry,
// passes the partial quotient along a chain of 6 divider cells for 11 rounds
// (66 quotient bits), mixes the six fields one per cycle and loads the
// output register.
// the block takes one item at a time; ready is low from a query beat until
// its result is handed to the output register, which holds it while the
// receiver stalls; the next item is taken while the result waits.
// reset empties the table (count to zero) and drops any pending result;
// memory contents are not cleared.
module pose_table_time_interpolator_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  ptti_pkg::t_action              i_action,
    input  logic [ptti_pkg::TimeW-1:0]     i_stamp_ms,
    input  logic signed [31:0]             i_roll_in,
    input  logic signed [31:0]             i_pitch_in,
    input  logic signed [31:0]             i_yaw_in,
    input  logic signed [31:0]             i_pos_x_in,
    input  logic signed [31:0]             i_pos_y_in,
    input  logic signed [31:0]             i_pos_z_in,
    output logic                           o_valid,
    input  logic                           i_ready,
    output ptti_pkg::t_status              o_status,
    output logic [ptti_pkg::TimeW-1:0]     o_stamp_out,
    output logic signed [31:0]             o_roll_out,
    output logic signed [31:0]             o_pitch_out,
    output logic signed [31:0]             o_yaw_out,
    output logic signed [31:0]             o_pos_x_out,
    output logic signed [31:0]             o_pos_y_out,
    output logic signed [31:0]             o_pos_z_out
);
    import ptti_pkg::*;
    localparam int NumCells = 6;
    localparam int DivBits = TimeW + 18;
    localparam int RoundW = $clog2(DivBits / NumCells + 1);
    localparam int StepW = $clog2(NumCells);
    localparam int FldW = $clog2(NumFields + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_FETCH, S_DIV, S_MIX, S_OUT
    } t_state;

    logic [TimeW-1:0] mem_t [TableDepth];
    logic [NumFields*ValW-1:0] mem_v [TableDepth];

    t_state r_state;
    logic [CntW-1:0] r_count;
    logic [CntW-1:0] r_pos;
    logic r_rd_vld;
    logic [TimeW-1:0] r_rd_t;
    logic [NumFields*ValW-1:0] r_rd_v;
    logic [TimeW-1:0] r_q;
    logic [NumFields*ValW-1:0] r_a;
    logic [TimeW-1:0] r_num;
    logic [TimeW-1:0] r_den;
    logic [RoundW-1:0] r_round;
    logic [StepW-1:0] r_step;
    logic [FldW-1:0] r_fld;
    logic [RatioW-1:0] r_ratio;
    logic r_first;
    t_div r_ring;
    t_div w_cell [NumCells+1];
    logic [NumFields*ValW-1:0] r_res;
    logic r_ovld;
    t_status r_st;
    logic [TimeW-1:0] r_ostamp;
    logic [NumFields*ValW-1:0] r_ovals;
    logic [IdxW-1:0] w_raddr;
    logic w_acc;
    logic w_div_en;
    logic [TimeW+17:0] w_dividend;
    logic [ValW:0] w_ab;
    logic [ValW:0] w_bb;
    logic [ValW+RatioW+1:0] w_sum;
    logic [ValW-1:0] w_mix;
    logic [QuotW-1:0] w_q;

    assign o_ready = (r_state == S_IDLE);
    assign w_acc = i_valid && o_ready;
    assign w_div_en = (r_state == S_DIV);
    assign w_dividend = {r_num, 16'd0};

    // memory write and registered read
    always_ff @(posedge i_clk) begin
        if (w_acc && i_action == ActAppend && r_count < CntW'(TableDepth)) begin
            mem_t[r_count[IdxW-1:0]] <= i_stamp_ms;
            mem_v[r_count[IdxW-1:0]] <= {i_pos_z_in, i_pos_y_in, i_pos_x_in,
                                         i_yaw_in, i_pitch_in, i_roll_in};
        end
        r_rd_t <= mem_t[w_raddr];
        r_rd_v <= mem_v[w_raddr];
    end

    // divider chain: NumCells cells, last cell fed back to the first from the second round on
    assign w_cell[0] = (r_round == '0) ? r_ring : w_cell[NumCells];
    for (genvar g = 0; g < NumCells; g++) begin : g_cell
        logic [$clog2(DivBits)-1:0] w_bi;
        assign w_bi = ($clog2(DivBits))'(DivBits - 1
                      - int'(r_round) * NumCells - g);
        ptti_div_cell u_cell (
            .i_clk (i_clk),
            .i_en  (w_div_en),
            .i_den (r_den),
            .i_d   (w_cell[g]),
            .i_bit (w_dividend[w_bi]),
            .o_d   (w_cell[g+1])
        );
    end

    // mixing of the field selected by r_fld
    assign w_q = w_cell[NumCells].quot;
    always_comb begin
        w_ab = {1'b0, ~r_a[r_fld[2:0]*ValW + ValW-1], r_a[r_fld[2:0]*ValW +: ValW-1]};
        w_bb = {1'b0, ~r_res[r_fld[2:0]*ValW + ValW-1],
                r_res[r_fld[2:0]*ValW +: ValW-1]};
        w_sum = (ValW+RatioW+2)'(w_ab) * (ValW+RatioW+2)'(RatioW'(65536) - r_ratio)
              + (ValW+RatioW+2)'(w_bb) * (ValW+RatioW+2)'(r_ratio)
              + (ValW+RatioW+2)'(32768);
        w_mix = w_sum[16 +: ValW] ^ {1'b1, {(ValW-1){1'b0}}};
    end

    assign w_raddr = (r_state == S_FETCH) ? IdxW'(r_pos - CntW'(1)) : r_pos[IdxW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ovld <= 1'b0;
            r_rd_vld <= 1'b0;
        end else begin
            if (r_ovld && i_ready && r_state != S_OUT) begin
                r_ovld <= 1'b0;
            end
            r_rd_vld <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        if (i_action == ActClear) begin
                            r_count <= '0;
                        end else if (i_action == ActAppend) begin
                            if (r_count < CntW'(TableDepth)) begin
                                r_count <= r_count + CntW'(1);
                            end
                        end else if (i_action == ActQuery) begin
                            r_q <= i_stamp_ms;
                            if (r_count == '0) begin
                                r_st <= StEmpty;
                                r_ostamp <= '0;
                                r_ovals <= '0;
                                r_state <= S_OUT;
                            end else begin
                                r_pos <= '0;
                                r_state <= S_SCAN;
                            end
                        end
                    end
                end
                S_SCAN: begin
                    // r_rd_t holds entry r_pos when r_rd_vld is set
                    if (!r_rd_vld) begin
                        r_rd_vld <= 1'b1;
                    end else if (r_rd_t >= r_q) begin
                        if (r_pos == '0) begin
                            r_st <= StFirst;
                            r_ostamp <= r_rd_t;
                            r_ovals <= r_rd_v;
                            r_state <= S_OUT;
                        end else begin
                            r_den <= r_rd_t;
                            r_res <= r_rd_v;
                            r_first <= 1'b1;
                            r_state <= S_FETCH;
                        end
                    end else if (r_pos == r_count - CntW'(1)) begin
                        r_st <= StLast;
                        r_ostamp <= r_rd_t;
                        r_ovals <= r_rd_v;
                        r_state <= S_OUT;
                    end else begin
                        r_pos <= r_pos + CntW'(1);
                        r_rd_vld <= 1'b0;
                    end
                end
                S_FETCH: begin
                    // wait for the earlier entry to come out of the memory
                    if (r_first) begin
                        r_first <= 1'b0;
                    end else begin
                        r_a <= r_rd_v;
                        r_num <= r_q - r_rd_t;
                        r_den <= r_den - r_rd_t;
                        r_ring <= '0;
                        r_round <= '0;
                        r_step <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_step == StepW'(NumCells - 1)) begin
                        r_step <= '0;
                        if (r_round == RoundW'(DivBits / NumCells - 1)) begin
                            r_fld <= '0;
                            r_first <= 1'b1;
                            r_state <= S_MIX;
                        end else begin
                            r_round <= r_round + RoundW'(1);
                        end
                    end else begin
                        r_step <= r_step + StepW'(1);
                    end
                end
                S_MIX: begin
                    if (r_first) begin
                        r_first <= 1'b0;
                        r_ratio <= (w_q > QuotW'(65536)) ? RatioW'(65536)
                                   : w_q[RatioW-1:0];
                    end else begin
                        r_ovals[r_fld[2:0]*ValW +: ValW] <= w_mix;
                        if (r_fld == FldW'(NumFields - 1)) begin
                            r_st <= StInterp;
                            r_ostamp <= r_q;
                            r_state <= S_OUT;
                        end else begin
                            r_fld <= r_fld + FldW'(1);
                        end
                    end
                end
                S_OUT: begin
                    if (!r_ovld || i_ready) begin
                        r_ovld <= 1'b1;
                        o_status <= r_st;
                        o_stamp_out <= r_ostamp;
                        {o_pos_z_out, o_pos_y_out, o_pos_x_out,
                         o_yaw_out, o_pitch_out, o_roll_out} <= r_ovals;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
    assign o_valid = r_ovld;
endmodule

[sv/ptti_div_cell.sv]
// one restoring division step, registered, handing the partial result on
// depends on ptti_pkg
module ptti_div_cell (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [ptti_pkg::TimeW-1:0]  i_den,
    input  ptti_pkg::t_div              i_d,
    input  logic                        i_bit,
    output ptti_pkg::t_div              o_d
);
    import ptti_pkg::*;
    logic [TimeW+1:0] w_sh;
    logic [TimeW+1:0] w_sub;
    t_div r_d;
    t_div n_d;

    always_comb begin
        w_sh = {i_d.rem, i_bit};
        w_sub = w_sh - {2'b00, i_den};
        n_d.quot = {i_d.quot[QuotW-2:0], ~w_sub[TimeW+1]};
        n_d.rem = w_sub[TimeW+1] ? w_sh[TimeW:0] : w_sub[TimeW:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end
    assign o_d = r_d;
endmodule

[sv/ptti_checker.sv]
// port-level checks for the pose table time interpolator
// depends on ptti_pkg and pose_table_time_interpolator_core
module ptti_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_ready,
    input ptti_pkg::t_action i_action,
    input logic              o_valid,
    input logic              i_ready,
    input ptti_pkg::t_status o_status,
    input logic [47:0]       o_stamp_out
);
    import ptti_pkg::*;
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status))
        else $error("result beat dropped");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_action == ActQuery |=> !o_ready)
        else $error("ready during query");
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == StEmpty |-> o_stamp_out == '0)
        else $error("empty result not zero");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("valid after reset");
endmodule

bind pose_table_time_interpolator_core ptti_checker u_ptti_checker (.*);
